@@ hdl/rlf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB linear fade package
// Shared payload types, request codes and the controller command bundle.
// ----------------------------------------------------------------------------
package rlf_pkg;

  // Fixed field widths of the request and result channels.
  localparam int COLOR_W   = 8;
  localparam int PWM_W     = 12;
  localparam int PWM_SCALE = 10;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;

  // Request type codes.
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // One input request.
  typedef struct packed {
    logic               req_type;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_t;

  // One result.
  typedef struct packed {
    logic [PWM_W-1:0] pwm_red;
    logic [PWM_W-1:0] pwm_green;
    logic [PWM_W-1:0] pwm_blue;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_target;
    logic            mul;
    logic            div_step;
    logic            fin;
    logic            out_load;
    logic [CH_W-1:0] ch;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/rlf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB linear fade controller
// Sequences the multiply and the bit-serial divide for each of the three
// color channels, then the output load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rlf_ctrl #(
  parameter int LEVEL_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         req_type,
  input  wire logic         fade_done,
  input  wire logic         out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output rlf_pkg::cmd_t     cmd
);

  localparam int CNT_W = $clog2(LEVEL_BITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                    state, state_next;
  logic [rlf_pkg::CH_W-1:0]  ch, ch_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic                      slot_free;

  // Requests are taken only while no other request is in progress.
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    ch_next    = ch;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.ch     = ch;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == rlf_pkg::REQ_SET) begin
            cmd.load_target = 1'b1;
          end else if (fade_done) begin
            state_next = S_OUT;
          end else begin
            ch_next    = '0;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = CNT_W'(LEVEL_BITS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (ch == rlf_pkg::CH_W'(rlf_pkg::NUM_CH - 1)) begin
          state_next = S_OUT;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = S_MUL;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/rlf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB linear fade datapath
// Holds the color and timer state, one shared multiplier, a restoring
// divider that yields one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module rlf_datapath #(
  parameter int LEVEL_BITS = 8,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIME_BITS-1:0] cfg_wr_data,
  input  wire rlf_pkg::in_t         in_data,
  input  wire rlf_pkg::cmd_t        cmd,
  output logic                      fade_done,
  output rlf_pkg::out_t             out_data
);

  localparam int L     = LEVEL_BITS;
  localparam int TB    = TIME_BITS;
  localparam int PW    = L + TB + 1;
  localparam int SW    = L + rlf_pkg::PWM_W;

  logic [TB-1:0]               t_ms;
  logic [L-1:0]                target [rlf_pkg::NUM_CH];
  logic [L-1:0]                start  [rlf_pkg::NUM_CH];
  logic [TB:0]                 elapsed;
  logic [L-1:0]                prod_lo;
  logic [TB-1:0]               rem;
  logic [L-1:0]                quo;
  logic [rlf_pkg::PWM_W-1:0]   res    [rlf_pkg::NUM_CH];

  logic [L-1:0]                in_lvl  [rlf_pkg::NUM_CH];
  logic [rlf_pkg::PWM_W-1:0]   tgt_pwm [rlf_pkg::NUM_CH];
  logic [L-1:0]                tgt_sel, st_sel, mag, level;
  logic                        neg;
  logic [PW-1:0]               product;
  logic [TB:0]                 rem_sh, rem_sub;
  logic                        ge;
  logic [L:0]                  level_up, level_dn;
  logic [SW-1:0]               level_sc;

  // The fade is over, or there is none, when the duration is zero or the
  // elapsed count has passed it.
  assign fade_done = (t_ms == '0) || (elapsed > {1'b0, t_ms});

  // New target levels at the level width.
  assign in_lvl[0] = L'(in_data.red);
  assign in_lvl[1] = L'(in_data.green);
  assign in_lvl[2] = L'(in_data.blue);

  // Target levels scaled to compare values, used when the fade is over.
  always_comb begin
    logic [SW-1:0] sc;
    for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
      sc         = SW'(target[i]) * SW'(rlf_pkg::PWM_SCALE);
      tgt_pwm[i] = sc[rlf_pkg::PWM_W-1:0];
    end
  end

  // Channel select and magnitude of the color difference.
  assign tgt_sel = target[cmd.ch];
  assign st_sel  = start[cmd.ch];
  assign neg     = (tgt_sel < st_sel);
  assign mag     = neg ? (st_sel - tgt_sel) : (tgt_sel - st_sel);
  assign product = PW'(mag) * PW'(elapsed);

  // One restoring divide step. The quotient never exceeds the magnitude,
  // so the partial remainder stays below the duration.
  assign rem_sh  = {rem, prod_lo[L-1]};
  assign ge      = (rem_sh >= {1'b0, t_ms});
  assign rem_sub = rem_sh - {1'b0, t_ms};

  // A falling channel rounds toward minus infinity: one more step down
  // whenever the division left a remainder.
  assign level_up = {1'b0, st_sel} + {1'b0, quo};
  assign level_dn = {1'b0, st_sel} - {1'b0, quo} - (L + 1)'(rem != '0);
  assign level    = neg ? level_dn[L-1:0] : level_up[L-1:0];
  assign level_sc = SW'(level) * SW'(rlf_pkg::PWM_SCALE);

  // Architectural state: duration, colors and elapsed count.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_ms    <= '0;
      elapsed <= '0;
      for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
        target[i] <= '0;
        start[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        t_ms <= cfg_wr_data;
      end
      if (cmd.load_target) begin
        for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
          start[i]  <= target[i];
          target[i] <= in_lvl[i];
        end
        if (t_ms != '0) begin
          elapsed <= '0;
        end
      end
      if (cmd.out_load) begin
        if (!fade_done) begin
          elapsed <= elapsed + 1'b1;
        end else if (t_ms != '0) begin
          for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
            start[i] <= target[i];
          end
        end
      end
    end
  end

  // Multiply, divide and result registers.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_lo <= product[L-1:0];
      rem     <= product[L+TB-1:L];
    end
    if (cmd.div_step) begin
      rem     <= ge ? rem_sub[TB-1:0] : rem_sh[TB-1:0];
      prod_lo <= prod_lo << 1;
      quo     <= {quo[L-2:0], ge};
    end
    if (cmd.fin) begin
      res[cmd.ch] <= level_sc[rlf_pkg::PWM_W-1:0];
    end
    if (cmd.out_load) begin
      out_data.pwm_red   <= fade_done ? tgt_pwm[0] : res[0];
      out_data.pwm_green <= fade_done ? tgt_pwm[1] : res[1];
      out_data.pwm_blue  <= fade_done ? tgt_pwm[2] : res[2];
    end
  end

endmodule
`default_nettype wire

@@ hdl/rgb_linear_fade_unit.sv @@
// A set-color request leaves the unit idle and gives no result. A tick while a fade
// runs gives its result after a multiply, a bit-serial divide and a final step for
// each of the three channels in turn, sharing one divider, then the output load; a
// tick with no fade running goes straight to the output load.
// Throughput: one request at a time; the next is taken once the result is loaded.
// Reset (rst, synchronous): colors, elapsed count and duration clear to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB linear fade unit
// Fades three color channels linearly from the old to the new target over
// a programmable number of millisecond ticks and emits PWM compare values.
// ----------------------------------------------------------------------------
module rgb_linear_fade_unit #(
  parameter int LEVEL_BITS = 8,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIME_BITS-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rlf_pkg::in_t         in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rlf_pkg::out_t             out_data
);

  rlf_pkg::cmd_t cmd;
  logic          fade_done;

  // Sequencer.
  rlf_ctrl #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .fade_done (fade_done),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // State, arithmetic and result register.
  rlf_datapath #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .fade_done   (fade_done),
    .out_data    (out_data)
  );

  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // A set-color request completes in its own cycle.
  a_set_quick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == rlf_pkg::REQ_SET) |=> !in_stall)
    else $error("set-color request left the unit busy");

  // A tick during a running fade starts the arithmetic sequence.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.req_type == rlf_pkg::REQ_TICK && !fade_done)
      |=> in_stall)
    else $error("fade tick did not start the divider");

  // A new result only ever follows a request in progress.
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB linear fade unit testbench
// Drives set-color and tick requests into the fade unit and compares every
// PWM result against a built-in model of the linear fade. Both sides idle and
// stall at random; directed tests cover the corner cases first.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES     = 3 * (rlf_pkg::COLOR_W + 2) + 2 + 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS     = 500;
  localparam int TIMEOUT_NS       = 1_000_000;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [15:0]         cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  rlf_pkg::in_t        in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rlf_pkg::out_t       out_data;

  // Model state of the fade.
  logic [rlf_pkg::COLOR_W-1:0] target_lvl [rlf_pkg::NUM_CH];
  logic [rlf_pkg::COLOR_W-1:0] origin_lvl [rlf_pkg::NUM_CH];
  logic [16:0]         fade_ticks;
  logic [15:0]         fade_len;

  // Expected PWM results, oldest first.
  rlf_pkg::out_t       pwm_expected [$];
  int                  error_count = 0;

  // Sender and receiver idling controls.
  bit                  sender_calm = 1'b0;
  int                  hold_seq = 0;
  int                  hold_seen = 0;
  int                  stall_left = 0;
  int                  mode_left = 0;
  bit                  receiver_calm = 1'b0;

  rgb_linear_fade_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always #1 clk = ~clk;

  // Pause length: mostly short, now and then long.
  function automatic int random_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic rlf_pkg::in_t make_request(logic kind, logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b);
    rlf_pkg::in_t item;
    item.req_type = kind;
    item.red      = r;
    item.green    = g;
    item.blue     = b;
    return item;
  endfunction

  function automatic logic [rlf_pkg::PWM_W-1:0] scale_level(int lvl);
    return rlf_pkg::PWM_W'((lvl * rlf_pkg::PWM_SCALE) & 'hFFF);
  endfunction

  // Apply one accepted request to the model; ticks queue an expected result.
  task automatic model_request(input rlf_pkg::in_t item);
    logic [rlf_pkg::COLOR_W-1:0] new_lvl [rlf_pkg::NUM_CH];
    int                 lvl [rlf_pkg::NUM_CH];
    bit                 running;
    longint             num;
    longint             den;
    longint             step;
    rlf_pkg::out_t      pwm;
    new_lvl[0] = item.red;
    new_lvl[1] = item.green;
    new_lvl[2] = item.blue;
    if (item.req_type == rlf_pkg::REQ_SET) begin
      for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
        origin_lvl[i] = target_lvl[i];
        target_lvl[i] = new_lvl[i];
      end
      if (fade_len != 0) fade_ticks = '0;
    end else begin
      running = (fade_len != 0) && (fade_ticks <= {1'b0, fade_len});
      den = longint'(fade_len);
      for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
        if (fade_len == 0) begin
          lvl[i] = int'(target_lvl[i]);
        end else if (!running) begin
          lvl[i] = int'(target_lvl[i]);
          origin_lvl[i] = target_lvl[i];
        end else begin
          num = longint'(int'(target_lvl[i]) - int'(origin_lvl[i])) * longint'(fade_ticks);
          // Interpolation floors toward minus infinity.
          if (num >= 0) step = num / den;
          else step = -((-num + den - 1) / den);
          lvl[i] = int'(origin_lvl[i]) + int'(step);
        end
      end
      if (running) fade_ticks = fade_ticks + 1'b1;
      pwm.pwm_red   = scale_level(lvl[0]);
      pwm.pwm_green = scale_level(lvl[1]);
      pwm.pwm_blue  = scale_level(lvl[2]);
      pwm_expected.push_back(pwm);
    end
  endtask

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input rlf_pkg::in_t item);
    int gap;
    gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : random_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= make_request(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                               8'($urandom));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    model_request(item);
  endtask

  task automatic send_set(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_request(make_request(rlf_pkg::REQ_SET, r, g, b));
  endtask

  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++)
      send_request(make_request(rlf_pkg::REQ_TICK, 8'($urandom), 8'($urandom),
                                8'($urandom)));
  endtask

  // Stop sending and wait until every expected result has been seen.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pwm_expected.size() != 0) @(posedge clk);
  endtask

  // Write the fade duration once the unit has gone idle.
  task automatic set_duration(input logic [15:0] len);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    fade_len = len;
    cfg_wr_en <= 1'b0;
  endtask

  // Compare one result against the oldest expectation.
  task automatic check_result(input rlf_pkg::out_t got);
    rlf_pkg::out_t want;
    if (pwm_expected.size() == 0) begin
      $error("unexpected result: pwm_red %0d, pwm_green %0d, pwm_blue %0d",
             got.pwm_red, got.pwm_green, got.pwm_blue);
      error_count++;
    end else begin
      want = pwm_expected.pop_front();
      if (got.pwm_red !== want.pwm_red) begin
        $error("pwm_red: expected %0d, actual %0d", want.pwm_red, got.pwm_red);
        error_count++;
      end
      if (got.pwm_green !== want.pwm_green) begin
        $error("pwm_green: expected %0d, actual %0d", want.pwm_green, got.pwm_green);
        error_count++;
      end
      if (got.pwm_blue !== want.pwm_blue) begin
        $error("pwm_blue: expected %0d, actual %0d", want.pwm_blue, got.pwm_blue);
        error_count++;
      end
    end
  endtask

  // Result side: check each accepted result and drive random stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
    if (hold_seen != hold_seq) begin
      hold_seen  = hold_seq;
      stall_left = LONG_HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      receiver_calm = ($urandom_range(0, 2) == 0);
      mode_left     = $urandom_range(100, 400);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
      stall_left = random_pause() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // After reset everything is zero, so a tick gives all-zero levels.
  task automatic test_reset_state();
    send_ticks(1);
  endtask

  // Zero duration jumps straight to each new target.
  task automatic test_immediate_jump();
    set_duration(16'd0);
    send_set(8'hFF, 8'hFF, 8'hFF);
    send_ticks(1);
    send_set(8'h00, 8'h00, 8'h00);
    send_ticks(1);
    send_set(8'hAA, 8'h55, 8'h0F);
    send_ticks(1);
  endtask

  // A short fade up and down, running past its end.
  task automatic test_linear_fade();
    set_duration(16'd3);
    send_set(8'hFF, 8'h00, 8'h80);
    send_ticks(5);
  endtask

  // A set color with zero duration keeps the elapsed count for later.
  task automatic test_zero_duration_hold();
    set_duration(16'd4);
    send_set(8'd200, 8'd10, 8'd90);
    send_ticks(2);
    set_duration(16'd0);
    send_set(8'd40, 8'd250, 8'd7);
    send_ticks(1);
    set_duration(16'd4);
    send_ticks(2);
  endtask

  // Shrinking the duration below the elapsed count ends the fade.
  task automatic test_duration_shrink();
    set_duration(16'hFFFF);
    send_set(8'd0, 8'd255, 8'd60);
    send_ticks(3);
    set_duration(16'd1);
    send_ticks(1);
  endtask

  // Results are held off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    set_duration(16'd20);
    send_set(8'd17, 8'd230, 8'd99);
    hold_seq <= hold_seq + 1;
    sender_calm = 1'b1;
    send_ticks(15);
    sender_calm = 1'b0;
    wait_for_results();
  endtask

  // Random fades: mostly a set color followed by a run of ticks, some noise.
  task automatic test_random_fades();
    int          sent;
    int          next_cfg;
    int          run;
    logic [15:0] len;
    sent     = 0;
    next_cfg = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_cfg) begin
        case ($urandom_range(0, 9))
          0:       len = 16'd0;
          1:       len = 16'd1;
          2:       len = 16'hFFFF;
          3, 4, 5: len = 16'($urandom_range(2, 8));
          6, 7:    len = 16'($urandom_range(9, 40));
          8:       len = 16'($urandom_range(41, 200));
          default: len = 16'($urandom_range(0, 65535));
        endcase
        set_duration(len);
        next_cfg = sent + $urandom_range(30, 70);
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 4) == 0)
          send_set($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                   $urandom_range(0, 1) ? 8'hFF : 8'h00);
        else
          send_set(8'($urandom), 8'($urandom), 8'($urandom));
        run = $urandom_range(0, ((fade_len < 16'd40) ? int'(fade_len) : 40) + 3);
        send_ticks(run);
        sent += run + 1;
      end else begin
        run = $urandom_range(1, 4);
        for (int i = 0; i < run; i++)
          send_request(make_request(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                                    8'($urandom)));
        sent += run;
      end
    end
    sender_calm = 1'b0;
  endtask

  // Main sequence.
  initial begin
    fade_ticks = '0;
    fade_len   = '0;
    for (int i = 0; i < rlf_pkg::NUM_CH; i++) begin
      target_lvl[i] = '0;
      origin_lvl[i] = '0;
    end
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_immediate_jump();
    test_linear_fade();
    test_zero_duration_hold();
    test_duration_shrink();
    test_backpressure();
    test_random_fades();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pwm_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rlf_pkg.sv
hdl/rlf_ctrl.sv
hdl/rlf_datapath.sv
hdl/rgb_linear_fade_unit.sv
sim/testbench.sv
